[rtl/spkd_pkg.sv]
package spkd_pkg;

    localparam int unsigned ROW_IDX_W = 4;
    localparam int unsigned ROW_W     = 16;
    localparam int unsigned MS_W      = 16;
    localparam int unsigned DEB_W     = 8;
    localparam int unsigned START_W   = 4;
    localparam int unsigned END_W     = 5;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DAT_W = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEBOUNCE_MS = 2'd0,
        CFG_SPDT_START  = 2'd1,
        CFG_SPDT_END    = 2'd2,
        CFG_UNUSED      = 2'd3
    } t_cfg_idx;

    localparam logic [DEB_W-1:0]   DEBOUNCE_MS_RST = 8'd5;
    localparam logic [START_W-1:0] SPDT_START_RST  = 4'd0;
    localparam logic [END_W-1:0]   SPDT_END_RST    = 5'd16;

    // spdt region bounds handed to the row evaluator
    typedef struct packed {
        logic [START_W-1:0] start_row;
        logic [END_W-1:0]   end_row;
    } t_spdt_cfg;

    // outcome of one row evaluation
    typedef struct packed {
        logic [ROW_W-1:0] cooked;
        logic             changed;
        logic             copied;
    } t_row_res;

endpackage

[rtl/spkd_row_eval.sv]
module spkd_row_eval (
    input  logic [spkd_pkg::ROW_IDX_W-1:0] i_row,
    input  logic [spkd_pkg::ROW_W-1:0]     i_cur,
    input  logic [spkd_pkg::ROW_W-1:0]     i_raw,
    input  logic [spkd_pkg::ROW_W-1:0]     i_nc,
    input  logic                           i_expired,
    input  spkd_pkg::t_spdt_cfg            i_cfg,
    output spkd_pkg::t_row_res             o_res
);
    import spkd_pkg::*;

    logic [END_W-1:0] span;
    logic [END_W-1:0] no_end;
    logic [END_W-1:0] row_x;
    logic             is_spdt;
    logic [ROW_W-1:0] delta;
    logic [ROW_W-1:0] flip;

    always_comb begin
        // empty span when the end row sits at or below the start row
        span    = (i_cfg.end_row > {1'b0, i_cfg.start_row}) ?
                  (i_cfg.end_row - {1'b0, i_cfg.start_row}) : '0;
        no_end  = {1'b0, i_cfg.start_row} + (span >> 1);
        row_x   = {1'b0, i_row};
        is_spdt = (i_row >= i_cfg.start_row) && (row_x < no_end);
        delta   = i_raw ^ i_cur;
        flip    = delta & (i_raw ^ i_nc);

        o_res.cooked  = i_cur;
        o_res.changed = 1'b0;
        o_res.copied  = 1'b0;
        if (is_spdt) begin
            o_res.cooked  = i_cur ^ flip;
            o_res.changed = |flip;
        end else if ((|delta) && i_expired) begin
            o_res.cooked  = i_raw;
            o_res.changed = 1'b1;
            o_res.copied  = 1'b1;
        end
    end

endmodule

[rtl/spdt_key_matrix_debounce.sv]
// channel | handshake                  | payload
// --------+----------------------------+-------------------------------------------
// in      | i_in_valid / o_in_stall    | i_row_index i_raw_row i_paired_nc_row
//         |                            | i_scan_changed i_now_ms
// out     | o_out_valid / i_out_stall  | o_cooked_row o_row_changed o_pass_changed
// cfg     | i_cfg_valid / o_cfg_ready  | i_cfg_index i_cfg_data
//
// one row a cycle sustained while the output is not stalled; the edge that accepts a
// transaction reads the cooked row memory into the read stage, which evaluates the row,
// writes it back and loads the output register once that register is not stalled
// reset is synchronous and clears the control state, the config registers and
// the per-row valid bits, so the cooked rows read as released straight away
// a stalled output register holds; o_in_stall rises only while it is full and stalled
module spdt_key_matrix_debounce #(
    parameter int ROWS = 16,
    parameter int COLS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,

    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [spkd_pkg::ROW_IDX_W-1:0] i_row_index,
    input  logic [spkd_pkg::ROW_W-1:0]     i_raw_row,
    input  logic [spkd_pkg::ROW_W-1:0]     i_paired_nc_row,
    input  logic                           i_scan_changed,
    input  logic [spkd_pkg::MS_W-1:0]      i_now_ms,

    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [spkd_pkg::ROW_W-1:0]     o_cooked_row,
    output logic                           o_row_changed,
    output logic                           o_pass_changed,

    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [spkd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [spkd_pkg::CFG_DAT_W-1:0] i_cfg_data
);
    import spkd_pkg::*;

    localparam int AW = $clog2(ROWS);
    localparam logic [5:0] ROWS_N = 6'(ROWS);
    // columns past COLS never reach the cooked bits
    localparam logic [ROW_W-1:0] KEEP_COLS =
        (COLS >= ROW_W) ? {ROW_W{1'b1}} : ROW_W'((32'd1 << COLS) - 32'd1);

    // config registers
    logic [DEB_W-1:0] r_debounce_ms;
    t_spdt_cfg        r_spdt;

    // global debounce state
    logic             r_timer_running;
    logic [MS_W-1:0]  r_timer_start;
    logic             r_pass_expired;
    logic             r_pass_any;
    logic             n_timer_running;
    logic [MS_W-1:0]  n_timer_start;
    logic             n_pass_expired;
    logic             n_pass_any;

    // cooked row store with a valid bit per row
    logic [ROW_W-1:0] r_mem [ROWS];
    logic [ROW_W-1:0] r_rd_data;
    logic [ROWS-1:0]  r_row_vld;

    // read stage
    logic                 r_s1_vld;
    logic [ROW_IDX_W-1:0] r_s1_row;
    logic [ROW_W-1:0]     r_s1_raw;
    logic [ROW_W-1:0]     r_s1_nc;
    logic                 r_s1_changed;
    logic [MS_W-1:0]      r_s1_now;
    logic                 r_s1_in_range;
    logic                 r_s1_rvld;
    logic                 r_s1_fwd;

    // last write, forwarded to a read issued on the same edge
    logic [ROW_W-1:0] r_fwd_data;

    // output register
    logic             r_out_vld;
    logic [ROW_W-1:0] r_out_cooked;
    logic             r_out_row_changed;
    logic             r_out_pass_changed;

    logic             in_accept;
    logic             adv1;
    logic             in_range_in;
    logic [AW-1:0]    rd_addr;
    logic [AW-1:0]    s1_addr;
    logic             wr_en;
    logic [ROW_W-1:0] s1_cur;
    logic [MS_W-1:0]  elapsed;
    logic             row0;
    logic             exp_eff;
    logic             any_eff;
    logic [ROW_W-1:0] cooked_out;
    logic             row_changed;
    t_row_res         row_res;

    assign adv1        = r_s1_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall  = r_s1_vld && !adv1;
    assign in_accept   = i_in_valid && !o_in_stall;
    assign in_range_in = {2'b00, i_row_index} < ROWS_N;
    assign rd_addr     = AW'({1'b0, i_row_index});
    assign s1_addr     = AW'({1'b0, r_s1_row});
    assign o_cfg_ready = 1'b1;

    // never-written rows read as released keys
    always_comb begin
        if (r_s1_fwd) begin
            s1_cur = r_fwd_data;
        end else if (r_s1_rvld) begin
            s1_cur = r_rd_data;
        end else begin
            s1_cur = '0;
        end
    end

    spkd_row_eval u_row_eval (
        .i_row     (r_s1_row),
        .i_cur     (s1_cur),
        .i_raw     (r_s1_raw),
        .i_nc      (r_s1_nc),
        .i_expired (exp_eff),
        .i_cfg     (r_spdt),
        .o_res     (row_res)
    );

    always_comb begin
        // row zero opens a pass: expiry is decided once here
        row0    = (r_s1_row == '0);
        elapsed = r_s1_now - r_timer_start;
        exp_eff = row0 ? (r_timer_running && (elapsed >= {8'h00, r_debounce_ms}))
                       : r_pass_expired;
        any_eff = row0 ? 1'b0 : r_pass_any;

        n_timer_running = r_timer_running;
        n_timer_start   = r_timer_start;
        n_pass_expired  = exp_eff;
        cooked_out      = '0;
        row_changed     = 1'b0;
        wr_en           = 1'b0;

        if (r_s1_changed) begin
            // changed scan restarts the timer and leaves the row alone
            n_timer_running = 1'b1;
            n_timer_start   = r_s1_now;
            n_pass_expired  = 1'b0;
            if (r_s1_in_range) begin
                cooked_out = s1_cur;
            end
        end else if (r_s1_in_range) begin
            cooked_out  = row_res.cooked;
            row_changed = row_res.changed;
            wr_en       = adv1;
            if (row_res.copied) begin
                n_timer_running = 1'b0;
            end
        end
        n_pass_any = any_eff || row_changed;
    end

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_ms    <= DEBOUNCE_MS_RST;
            r_spdt.start_row <= SPDT_START_RST;
            r_spdt.end_row   <= SPDT_END_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_DEBOUNCE_MS: r_debounce_ms    <= i_cfg_data;
                CFG_SPDT_START:  r_spdt.start_row <= i_cfg_data[START_W-1:0];
                CFG_SPDT_END:    r_spdt.end_row   <= i_cfg_data[END_W-1:0];
                default: ;
            endcase
        end
    end

    // memory: one read port at transaction time, one write port at evaluation
    always_ff @(posedge i_clk) begin
        if (in_accept && in_range_in) begin
            r_rd_data <= r_mem[rd_addr];
        end
        if (wr_en) begin
            r_mem[s1_addr] <= row_res.cooked;
            r_fwd_data     <= row_res.cooked;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
        end else if (wr_en) begin
            r_row_vld[s1_addr] <= 1'b1;
        end
    end

    // read stage payload
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_row      <= i_row_index;
            r_s1_raw      <= i_raw_row & KEEP_COLS;
            r_s1_nc       <= i_paired_nc_row & KEEP_COLS;
            r_s1_changed  <= i_scan_changed;
            r_s1_now      <= i_now_ms;
            r_s1_in_range <= in_range_in;
            r_s1_rvld     <= in_range_in && r_row_vld[rd_addr];
            r_s1_fwd      <= wr_en && (s1_addr == rd_addr);
        end
    end

    // control and global state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld        <= 1'b0;
            r_out_vld       <= 1'b0;
            r_timer_running <= 1'b0;
            r_timer_start   <= '0;
            r_pass_expired  <= 1'b0;
            r_pass_any      <= 1'b0;
        end else begin
            if (in_accept) begin
                r_s1_vld <= 1'b1;
            end else if (adv1) begin
                r_s1_vld <= 1'b0;
            end
            if (adv1) begin
                r_out_vld       <= 1'b1;
                r_timer_running <= n_timer_running;
                r_timer_start   <= n_timer_start;
                r_pass_expired  <= n_pass_expired;
                r_pass_any      <= n_pass_any;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_out_cooked       <= cooked_out;
            r_out_row_changed  <= row_changed;
            r_out_pass_changed <= n_pass_any;
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_cooked_row   = r_out_cooked;
    assign o_row_changed  = r_out_row_changed;
    assign o_pass_changed = r_out_pass_changed;

endmodule

[rtl/spkd_checker.sv]
module spkd_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       o_in_stall,
    input logic                       o_out_valid,
    input logic                       i_out_stall,
    input logic [spkd_pkg::ROW_W-1:0] o_cooked_row,
    input logic                       o_row_changed,
    input logic                       o_pass_changed
);
    import spkd_pkg::*;

    // a changed row always marks its pass as changed
    a_row_implies_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_row_changed |-> o_pass_changed)
        else $error("row change without pass change");

    // input back-pressure only comes from a full, stalled output
    a_stall_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled with output free");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output valid dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            $stable(o_cooked_row) && $stable(o_row_changed) && $stable(o_pass_changed))
        else $error("stalled output changed");

endmodule

bind spdt_key_matrix_debounce spkd_checker u_spkd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_cooked_row   (o_cooked_row),
    .o_row_changed  (o_row_changed),
    .o_pass_changed (o_pass_changed)
);
